@@ rtl/core/ktb_pkg.sv @@
// ----------------------------------------------------------------------------
// ktb_pkg
// Shared widths, codes and types of the keyed token bucket limiter.
// ----------------------------------------------------------------------------
`default_nettype none

package ktb_pkg;

   localparam int FRACTION_BITS = 16;

   localparam int ACTION_W   = 2;
   localparam int TAG_W      = 32;
   localparam int LEN_W      = 13;
   localparam int COST_W     = 32;
   localparam int TIME_W     = 48;
   localparam int STATUS_W   = 4;
   localparam int COUNT_W    = 11;
   localparam int BYTES_W    = 29;
   localparam int PERMIT_W   = 20;
   localparam int RATE_W     = 30;
   localparam int INTERVAL_W = 27;
   localparam int IDLE_W     = 30;
   localparam int CSR_W      = 30;
   localparam int CSR_IDX_W  = 3;

   localparam int TOKEN_W = RATE_W + FRACTION_BITS;
   localparam int PROD_W  = TIME_W + RATE_W;
   localparam int NUM_W   = PROD_W + FRACTION_BITS;
   localparam int DIV_W   = RATE_W + FRACTION_BITS;

   localparam logic [TIME_W-1:0] TIME_MAX = '1;
   localparam logic [TIME_W-1:0] DAY_MS   = 48'd86400000;

   localparam int DEF_TABLE_DEPTH   = 1024;
   localparam int DEF_MAX_KEY_BYTES = 4096;

   localparam logic [COUNT_W-1:0]    RST_MAX_KEYS   = 11'd1024;
   localparam logic [BYTES_W-1:0]    RST_MAX_BYTES  = 29'd1048576;
   localparam logic [RATE_W-1:0]     RST_REFILL     = 30'd1;
   localparam logic [RATE_W-1:0]     RST_BURST      = 30'd1;
   localparam logic [INTERVAL_W-1:0] RST_INTERVAL   = 27'd1000;
   localparam logic [IDLE_W-1:0]     RST_IDLE       = 30'd60000;
   localparam logic [PERMIT_W-1:0]   RST_PER_KEY    = 20'd1;
   localparam logic [PERMIT_W-1:0]   RST_TOTAL      = 20'd1;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_MAX_KEYS   = 3'd0,
      REG_MAX_BYTES  = 3'd1,
      REG_REFILL     = 3'd2,
      REG_BURST      = 3'd3,
      REG_INTERVAL   = 3'd4,
      REG_IDLE       = 3'd5,
      REG_PER_KEY    = 3'd6,
      REG_TOTAL      = 3'd7
   } csr_index_type;

   typedef enum logic [ACTION_W-1:0] {
      ACT_ACQUIRE = 2'd0,
      ACT_RELEASE = 2'd1,
      ACT_PRUNE   = 2'd2,
      ACT_CLOSE   = 2'd3
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_ADMITTED        = 4'd0,
      ST_RATE            = 4'd1,
      ST_KEY_CONC        = 4'd2,
      ST_TOTAL_CONC      = 4'd3,
      ST_KEY_CAP         = 4'd4,
      ST_INVALID         = 4'd5,
      ST_TOO_LARGE       = 4'd6,
      ST_CLOSED          = 4'd7,
      ST_DONE            = 4'd8,
      ST_UNKNOWN_RELEASE = 4'd9
   } status_type;

   typedef struct packed {
      logic                valid;
      logic [TAG_W-1:0]    tag;
      logic [LEN_W-1:0]    len;
      logic [TOKEN_W-1:0]  tokens;
      logic [PERMIT_W-1:0] active;
      logic [TIME_W-1:0]   refill_t;
      logic [TIME_W-1:0]   seen_t;
   } slot_type;

   typedef struct packed {
      logic              start;
      logic              shift_en;
      logic [TIME_W-1:0] mul_a;
      logic [RATE_W-1:0] mul_b;
      logic [DIV_W-1:0]  divisor;
   } mdv_cmd_type;

   typedef struct packed {
      logic             done;
      logic [NUM_W-1:0] quotient;
      logic             rem_nz;
   } mdv_res_type;

endpackage

`default_nettype wire

@@ rtl/core/ktb_if.sv @@
// ----------------------------------------------------------------------------
// ktb_if
// Request and response channel interfaces with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface ktb_req_if;
   logic                          valid;
   logic                          ready;
   logic [ktb_pkg::ACTION_W-1:0]  action;
   logic [ktb_pkg::TAG_W-1:0]     key_id;
   logic [ktb_pkg::LEN_W-1:0]     key_length;
   logic [ktb_pkg::COST_W-1:0]    cost;
   logic [ktb_pkg::TIME_W-1:0]    now_ms;

   modport source (output valid, action, key_id, key_length, cost, now_ms, input ready);
   modport sink   (input valid, action, key_id, key_length, cost, now_ms, output ready);
endinterface

interface ktb_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ktb_pkg::STATUS_W-1:0]  status;
   logic [ktb_pkg::TIME_W-1:0]    retry_after_ms;
   logic [ktb_pkg::COUNT_W-1:0]   removed_count;
   logic [ktb_pkg::COUNT_W-1:0]   entry_count;
   logic [ktb_pkg::BYTES_W-1:0]   key_bytes_used;
   logic [ktb_pkg::PERMIT_W-1:0]  active_total;

   modport source (output valid, status, retry_after_ms, removed_count, entry_count,
                   key_bytes_used, active_total, input ready);
   modport sink   (input valid, status, retry_after_ms, removed_count, entry_count,
                   key_bytes_used, active_total, output ready);
endinterface

`default_nettype wire

@@ rtl/core/keyed_token_bucket_limiter.sv @@
// ----------------------------------------------------------------------------
// keyed_token_bucket_limiter
// Per-key token bucket admission with per-key and total permit caps.
//
// Requests (acquire, release, prune, close) enter on req_ch; each gives one
// response on rsp_ch. All slot state sits in one table memory that the
// sequencer reads, updates and writes back one slot at a time.
// Work per request:
//   refusal on the argument, closed or total-cap checks: no table access
//   key search: a read and a check per slot up to the match (all on a miss)
//   bucket refill and retry delay: one run each of the shared serial
//   multiply/divide unit (30 multiply steps, 94 divide steps)
//   prune and close: a pass over every slot, refilling each valid slot and
//   dividing out the full time of each inactive slot that stays
// After reset a clearing pass over every slot invalidates the table;
// no request is taken during it, configuration writes are.
// The finished response sits in an output register; the next request is
// taken while it waits. A stalled receiver holds back only the next
// response, not the work on the next request.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_token_bucket_limiter #(
   parameter int TABLE_DEPTH   = ktb_pkg::DEF_TABLE_DEPTH,
   parameter int MAX_KEY_BYTES = ktb_pkg::DEF_MAX_KEY_BYTES
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   ktb_req_if.sink                           req_ch,
   ktb_rsp_if.source                         rsp_ch,
   input  wire logic                         csr_we,
   input  wire logic [ktb_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [ktb_pkg::CSR_W-1:0]    csr_wdata
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int KW = (CW > ktb_pkg::COUNT_W) ? CW : ktb_pkg::COUNT_W;
   localparam int TW = ktb_pkg::TIME_W;
   localparam int OK = ktb_pkg::TOKEN_W;

   typedef enum logic [19:0] {
      S_CLEAR    = 20'h00001,
      S_IDLE     = 20'h00002,
      S_SRCH_RD  = 20'h00004,
      S_SRCH_CHK = 20'h00008,
      S_FOUND    = 20'h00010,
      S_MISS     = 20'h00020,
      S_INSERT   = 20'h00040,
      S_RF       = 20'h00080,
      S_RF_WAIT  = 20'h00100,
      S_ACQ_EVAL = 20'h00200,
      S_RT_WAIT  = 20'h00400,
      S_WB       = 20'h00800,
      S_PR_INIT  = 20'h01000,
      S_PR_RD    = 20'h02000,
      S_PR_CHK   = 20'h04000,
      S_PR_DEC   = 20'h08000,
      S_PR_FT    = 20'h10000,
      S_PR_WB    = 20'h20000,
      S_PR_END   = 20'h40000,
      S_RESP     = 20'h80000
   } state_type;

   // control state
   state_type                            state_ff, state_in;
   logic [AW-1:0]                        idx_ff, idx_in;
   logic [CW-1:0]                        cnt_ff, cnt_in;
   logic [ktb_pkg::BYTES_W-1:0]          bytes_ff, bytes_in;
   logic [ktb_pkg::PERMIT_W-1:0]         permits_ff, permits_in;
   logic [TW-1:0]                        hold_ff, hold_in;
   logic                                 shut_ff, shut_in;
   logic                                 rsp_valid_ff, rsp_valid_in;

   // configuration
   logic [ktb_pkg::COUNT_W-1:0]          max_keys_ff;
   logic [ktb_pkg::BYTES_W-1:0]          max_bytes_ff;
   logic [ktb_pkg::RATE_W-1:0]           refill_ff;
   logic [ktb_pkg::RATE_W-1:0]           burst_ff;
   logic [ktb_pkg::INTERVAL_W-1:0]       interval_ff;
   logic [ktb_pkg::IDLE_W-1:0]           idle_ff;
   logic [ktb_pkg::PERMIT_W-1:0]         per_key_ff;
   logic [ktb_pkg::PERMIT_W-1:0]         total_ff;

   // request working registers
   ktb_pkg::action_type                  action_ff, action_in;
   logic [ktb_pkg::TAG_W-1:0]            tag_ff, tag_in;
   logic [ktb_pkg::LEN_W-1:0]            len_ff, len_in;
   logic [ktb_pkg::COST_W-1:0]           cost_ff, cost_in;
   logic [TW-1:0]                        now_ff, now_in;
   ktb_pkg::slot_type                    rec_ff, rec_in;
   logic [AW-1:0]                        match_ff, match_in;
   logic [AW-1:0]                        free_ff, free_in;
   logic                                 free_found_ff, free_found_in;
   logic                                 in_prune_ff, in_prune_in;
   logic                                 pressure_ff, pressure_in;
   logic                                 prune_after_ff, prune_after_in;
   logic [CW-1:0]                        removed_ff, removed_in;
   logic [TW-1:0]                        retry_min_ff, retry_min_in;
   ktb_pkg::status_type                  status_ff, status_in;
   logic [TW-1:0]                        retry_ff, retry_in;

   // response register
   logic [ktb_pkg::STATUS_W-1:0]         o_status_ff;
   logic [TW-1:0]                        o_retry_ff;
   logic [ktb_pkg::COUNT_W-1:0]          o_removed_ff;
   logic [ktb_pkg::COUNT_W-1:0]          o_count_ff;
   logic [ktb_pkg::BYTES_W-1:0]          o_bytes_ff;
   logic [ktb_pkg::PERMIT_W-1:0]         o_active_ff;

   logic                                 accept;
   logic                                 rsp_load;
   logic                                 tbl_we;
   logic [AW-1:0]                        tbl_waddr;
   ktb_pkg::slot_type                    tbl_wdata;
   ktb_pkg::slot_type                    tbl_rdata;
   ktb_pkg::mdv_cmd_type                 mdv_cmd;
   ktb_pkg::mdv_res_type                 mdv_res;

   logic [ktb_pkg::RATE_W-1:0]           r_eff;
   logic [ktb_pkg::INTERVAL_W-1:0]       i_eff;
   logic [OK-1:0]                        bf;
   logic [TW-1:0]                        cf;
   logic                                 idx_last;
   logic                                 no_room;
   logic [ktb_pkg::BYTES_W-1:0]          room;

   assign r_eff    = (refill_ff == '0) ? ktb_pkg::RATE_W'(1) : refill_ff;
   assign i_eff    = (interval_ff == '0) ? ktb_pkg::INTERVAL_W'(1) : interval_ff;
   assign bf       = OK'(burst_ff) << ktb_pkg::FRACTION_BITS;
   assign cf       = TW'(cost_ff) << ktb_pkg::FRACTION_BITS;
   assign idx_last = (idx_ff == AW'(TABLE_DEPTH - 1));
   assign room     = (max_bytes_ff > bytes_ff) ? (max_bytes_ff - bytes_ff) : '0;
   assign no_room  = (KW'(cnt_ff) >= KW'(max_keys_ff)) || (cnt_ff >= CW'(TABLE_DEPTH))
                     || (ktb_pkg::BYTES_W'(len_ff) > room);

   assign req_ch.ready = (state_ff == S_IDLE);
   assign accept       = req_ch.valid && (state_ff == S_IDLE);
   assign rsp_load     = (state_ff == S_RESP) && (!rsp_valid_ff || rsp_ch.ready);

   ktb_table #(.DEPTH(TABLE_DEPTH)) u_table (
      .clock   (clock),
      .rd_addr (idx_ff),
      .rd_data (tbl_rdata),
      .wr_en   (tbl_we),
      .wr_addr (tbl_waddr),
      .wr_data (tbl_wdata)
   );

   ktb_muldiv u_muldiv (
      .clock (clock),
      .reset (reset),
      .cmd   (mdv_cmd),
      .res   (mdv_res)
   );

   // table write port
   always_comb begin
      tbl_we    = (state_ff == S_CLEAR) || (state_ff == S_WB) || (state_ff == S_PR_WB);
      tbl_waddr = (state_ff == S_WB) ? match_ff : idx_ff;
      tbl_wdata = (state_ff == S_CLEAR) ? '0 : rec_ff;
   end

   // operands of the multiply/divide unit
   always_comb begin
      logic [OK-1:0] missing;
      missing = (rec_ff.tokens < bf) ? (bf - rec_ff.tokens) : '0;
      mdv_cmd.shift_en = (state_ff == S_RF);
      mdv_cmd.mul_b    = (state_ff == S_RF) ? r_eff : ktb_pkg::RATE_W'(i_eff);
      mdv_cmd.divisor  = (state_ff == S_RF) ? ktb_pkg::DIV_W'(i_eff)
                                            : (ktb_pkg::DIV_W'(r_eff) << ktb_pkg::FRACTION_BITS);
      if (state_ff == S_RF) begin
         mdv_cmd.mul_a = now_ff - rec_ff.refill_t;
      end else if (state_ff == S_ACQ_EVAL) begin
         mdv_cmd.mul_a = cf - TW'(rec_ff.tokens);
      end else begin
         mdv_cmd.mul_a = TW'(missing);
      end
      mdv_cmd.start = ((state_ff == S_RF) && (now_ff > rec_ff.refill_t))
                   || ((state_ff == S_ACQ_EVAL) && (rec_ff.active < per_key_ff)
                       && (TW'(rec_ff.tokens) < cf))
                   || ((state_ff == S_PR_DEC) && (rec_ff.active == '0)
                       && !(shut_ff || ((rec_ff.tokens >= bf)
                            && (pressure_ff || ((now_ff >= rec_ff.seen_t)
                                && ((now_ff - rec_ff.seen_t) >= TW'(idle_ff)))))));
   end

   // sequencer
   always_comb begin
      ktb_pkg::slot_type           r;
      logic [OK:0]                 sum;
      logic [TW:0]                 tsum;
      logic [TW-1:0]               ms;
      logic [TW-1:0]               tfull;
      logic [TW-1:0]               rt;
      logic                        full;
      logic                        idle;
      state_in       = state_ff;
      idx_in         = idx_ff;
      cnt_in         = cnt_ff;
      bytes_in       = bytes_ff;
      permits_in     = permits_ff;
      hold_in        = hold_ff;
      shut_in        = shut_ff;
      action_in      = action_ff;
      tag_in         = tag_ff;
      len_in         = len_ff;
      cost_in        = cost_ff;
      now_in         = now_ff;
      rec_in         = rec_ff;
      match_in       = match_ff;
      free_in        = free_ff;
      free_found_in  = free_found_ff;
      in_prune_in    = in_prune_ff;
      pressure_in    = pressure_ff;
      prune_after_in = prune_after_ff;
      removed_in     = removed_ff;
      retry_min_in   = retry_min_ff;
      status_in      = status_ff;
      retry_in       = retry_ff;
      r     = tbl_rdata;
      sum   = (OK + 1)'(rec_ff.tokens) + (OK + 1)'(mdv_res.quotient[OK-1:0]);
      ms    = (mdv_res.quotient > ktb_pkg::NUM_W'(ktb_pkg::DAY_MS))
              ? ktb_pkg::DAY_MS : mdv_res.quotient[TW-1:0];
      tsum  = (TW + 1)'(rec_ff.refill_t) + (TW + 1)'(ms);
      tfull = tsum[TW] ? ktb_pkg::TIME_MAX : tsum[TW-1:0];
      rt    = mdv_res.quotient[TW-1:0] + TW'(mdv_res.rem_nz);
      full  = rec_ff.tokens >= bf;
      idle  = (now_ff >= rec_ff.seen_t) && ((now_ff - rec_ff.seen_t) >= TW'(idle_ff));

      case (state_ff)
         S_CLEAR: begin
            if (idx_last) begin
               idx_in   = '0;
               state_in = S_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (accept) begin
               action_in     = ktb_pkg::action_type'(req_ch.action);
               tag_in        = req_ch.key_id;
               len_in        = req_ch.key_length;
               cost_in       = req_ch.cost;
               now_in        = req_ch.now_ms;
               removed_in    = '0;
               retry_in      = '0;
               idx_in        = '0;
               free_found_in = 1'b0;
               pressure_in   = 1'b0;
               case (ktb_pkg::action_type'(req_ch.action))
                  ktb_pkg::ACT_ACQUIRE: begin
                     state_in = S_RESP;
                     if (req_ch.key_length == '0 || req_ch.cost == '0) begin
                        status_in = ktb_pkg::ST_INVALID;
                     end else if ((req_ch.key_length > ktb_pkg::LEN_W'(MAX_KEY_BYTES))
                                  || (req_ch.cost > ktb_pkg::COST_W'(burst_ff))) begin
                        status_in = ktb_pkg::ST_TOO_LARGE;
                     end else if (shut_ff) begin
                        status_in = ktb_pkg::ST_CLOSED;
                     end else if (permits_ff >= total_ff) begin
                        status_in = ktb_pkg::ST_TOTAL_CONC;
                     end else begin
                        state_in = S_SRCH_RD;
                     end
                  end
                  ktb_pkg::ACT_RELEASE: state_in = S_SRCH_RD;
                  ktb_pkg::ACT_PRUNE:   state_in = S_PR_INIT;
                  ktb_pkg::ACT_CLOSE: begin
                     shut_in  = 1'b1;
                     state_in = S_PR_INIT;
                  end
                  default: state_in = S_PR_INIT;
               endcase
            end
         end
         S_SRCH_RD: state_in = S_SRCH_CHK;
         S_SRCH_CHK: begin
            if (r.valid && r.tag == tag_ff && r.len == len_ff) begin
               rec_in   = r;
               match_in = idx_ff;
               state_in = S_FOUND;
            end else begin
               if (!r.valid && !free_found_ff) begin
                  free_in       = idx_ff;
                  free_found_in = 1'b1;
               end
               if (idx_last) begin
                  if (action_ff == ktb_pkg::ACT_RELEASE) begin
                     status_in = ktb_pkg::ST_UNKNOWN_RELEASE;
                     state_in  = S_RESP;
                  end else begin
                     state_in = S_MISS;
                  end
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_SRCH_RD;
               end
            end
         end
         S_FOUND: begin
            if (action_ff == ktb_pkg::ACT_RELEASE) begin
               if (rec_ff.active == '0) begin
                  status_in = ktb_pkg::ST_UNKNOWN_RELEASE;
                  state_in  = S_RESP;
               end else begin
                  rec_in.active  = rec_ff.active - 1'b1;
                  rec_in.seen_t  = now_ff;
                  permits_in     = (permits_ff != '0) ? permits_ff - 1'b1 : permits_ff;
                  hold_in        = '0;
                  status_in      = ktb_pkg::ST_DONE;
                  prune_after_in = shut_ff;
                  state_in       = S_WB;
               end
            end else begin
               in_prune_in = 1'b0;
               state_in    = S_RF;
            end
         end
         S_MISS: begin
            if (no_room && now_ff >= hold_ff) begin
               pressure_in = 1'b1;
               state_in    = S_PR_INIT;
            end else begin
               state_in = S_INSERT;
            end
         end
         S_INSERT: begin
            pressure_in = 1'b0;
            if (no_room || !free_found_ff) begin
               status_in = ktb_pkg::ST_KEY_CAP;
               state_in  = S_RESP;
            end else begin
               rec_in.valid    = 1'b1;
               rec_in.tag      = tag_ff;
               rec_in.len      = len_ff;
               rec_in.tokens   = bf;
               rec_in.active   = '0;
               rec_in.refill_t = now_ff;
               rec_in.seen_t   = now_ff;
               match_in        = free_ff;
               bytes_in        = bytes_ff + ktb_pkg::BYTES_W'(len_ff);
               cnt_in          = cnt_ff + 1'b1;
               state_in        = S_ACQ_EVAL;
            end
         end
         S_RF: begin
            if (now_ff > rec_ff.refill_t) begin
               state_in = S_RF_WAIT;
            end else begin
               state_in = in_prune_ff ? S_PR_DEC : S_ACQ_EVAL;
            end
         end
         S_RF_WAIT: begin
            if (mdv_res.done) begin
               if ((mdv_res.quotient >= ktb_pkg::NUM_W'(bf)) || (sum >= (OK + 1)'(bf))) begin
                  rec_in.tokens = bf;
               end else begin
                  rec_in.tokens = sum[OK-1:0];
               end
               rec_in.refill_t = now_ff;
               state_in = in_prune_ff ? S_PR_DEC : S_ACQ_EVAL;
            end
         end
         S_ACQ_EVAL: begin
            rec_in.seen_t  = now_ff;
            prune_after_in = 1'b0;
            if (rec_ff.active >= per_key_ff) begin
               status_in = ktb_pkg::ST_KEY_CONC;
               state_in  = S_WB;
            end else if (TW'(rec_ff.tokens) < cf) begin
               state_in = S_RT_WAIT;
            end else begin
               rec_in.tokens = OK'(TW'(rec_ff.tokens) - cf);
               rec_in.active = rec_ff.active + 1'b1;
               permits_in    = permits_ff + 1'b1;
               status_in     = ktb_pkg::ST_ADMITTED;
               state_in      = S_WB;
            end
         end
         S_RT_WAIT: begin
            if (mdv_res.done) begin
               if (mdv_res.quotient >= ktb_pkg::NUM_W'(ktb_pkg::TIME_MAX)) begin
                  retry_in = ktb_pkg::TIME_MAX;
               end else if (rt == '0) begin
                  retry_in = TW'(1);
               end else begin
                  retry_in = rt;
               end
               status_in = ktb_pkg::ST_RATE;
               state_in  = S_WB;
            end
         end
         S_WB: begin
            state_in = prune_after_ff ? S_PR_INIT : S_RESP;
         end
         S_PR_INIT: begin
            idx_in        = '0;
            in_prune_in   = 1'b1;
            free_found_in = 1'b0;
            retry_min_in  = ktb_pkg::TIME_MAX;
            state_in      = S_PR_RD;
         end
         S_PR_RD: state_in = S_PR_CHK;
         S_PR_CHK: begin
            if (!r.valid) begin
               if (!free_found_ff) begin
                  free_in       = idx_ff;
                  free_found_in = 1'b1;
               end
               if (idx_last) begin
                  state_in = S_PR_END;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_PR_RD;
               end
            end else begin
               rec_in   = r;
               state_in = S_RF;
            end
         end
         S_PR_DEC: begin
            if (rec_ff.active == '0 && (shut_ff || (full && (pressure_ff || idle)))) begin
               bytes_in     = (bytes_ff >= ktb_pkg::BYTES_W'(rec_ff.len))
                              ? bytes_ff - ktb_pkg::BYTES_W'(rec_ff.len) : '0;
               rec_in.valid = 1'b0;
               removed_in   = removed_ff + 1'b1;
               cnt_in       = cnt_ff - 1'b1;
               if (!free_found_ff) begin
                  free_in       = idx_ff;
                  free_found_in = 1'b1;
               end
               state_in = S_PR_WB;
            end else if (rec_ff.active == '0) begin
               state_in = S_PR_FT;
            end else begin
               state_in = S_PR_WB;
            end
         end
         S_PR_FT: begin
            if (mdv_res.done) begin
               if (tfull < retry_min_ff) begin
                  retry_min_in = tfull;
               end
               state_in = S_PR_WB;
            end
         end
         S_PR_WB: begin
            if (idx_last) begin
               state_in = S_PR_END;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_PR_RD;
            end
         end
         S_PR_END: begin
            idx_in = '0;
            if (pressure_ff) begin
               hold_in  = retry_min_ff;
               state_in = S_INSERT;
            end else begin
               status_in = ktb_pkg::ST_DONE;
               state_in  = S_RESP;
            end
         end
         S_RESP: begin
            if (rsp_load) begin
               idx_in   = '0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         idx_ff       <= '0;
         cnt_ff       <= '0;
         bytes_ff     <= '0;
         permits_ff   <= '0;
         hold_ff      <= '0;
         shut_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         cnt_ff       <= cnt_in;
         bytes_ff     <= bytes_in;
         permits_ff   <= permits_in;
         hold_ff      <= hold_in;
         shut_ff      <= shut_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_keys_ff  <= ktb_pkg::RST_MAX_KEYS;
         max_bytes_ff <= ktb_pkg::RST_MAX_BYTES;
         refill_ff    <= ktb_pkg::RST_REFILL;
         burst_ff     <= ktb_pkg::RST_BURST;
         interval_ff  <= ktb_pkg::RST_INTERVAL;
         idle_ff      <= ktb_pkg::RST_IDLE;
         per_key_ff   <= ktb_pkg::RST_PER_KEY;
         total_ff     <= ktb_pkg::RST_TOTAL;
      end else if (csr_we) begin
         case (csr_index)
            ktb_pkg::REG_MAX_KEYS:  max_keys_ff  <= csr_wdata[ktb_pkg::COUNT_W-1:0];
            ktb_pkg::REG_MAX_BYTES: max_bytes_ff <= csr_wdata[ktb_pkg::BYTES_W-1:0];
            ktb_pkg::REG_REFILL:    refill_ff    <= csr_wdata[ktb_pkg::RATE_W-1:0];
            ktb_pkg::REG_BURST:     burst_ff     <= csr_wdata[ktb_pkg::RATE_W-1:0];
            ktb_pkg::REG_INTERVAL:  interval_ff  <= csr_wdata[ktb_pkg::INTERVAL_W-1:0];
            ktb_pkg::REG_IDLE:      idle_ff      <= csr_wdata[ktb_pkg::IDLE_W-1:0];
            ktb_pkg::REG_PER_KEY:   per_key_ff   <= csr_wdata[ktb_pkg::PERMIT_W-1:0];
            ktb_pkg::REG_TOTAL:     total_ff     <= csr_wdata[ktb_pkg::PERMIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      action_ff      <= action_in;
      tag_ff         <= tag_in;
      len_ff         <= len_in;
      cost_ff        <= cost_in;
      now_ff         <= now_in;
      rec_ff         <= rec_in;
      match_ff       <= match_in;
      free_ff        <= free_in;
      free_found_ff  <= free_found_in;
      in_prune_ff    <= in_prune_in;
      pressure_ff    <= pressure_in;
      prune_after_ff <= prune_after_in;
      removed_ff     <= removed_in;
      retry_min_ff   <= retry_min_in;
      status_ff      <= status_in;
      retry_ff       <= retry_in;
      if (rsp_load) begin
         o_status_ff  <= status_ff;
         o_retry_ff   <= retry_ff;
         o_removed_ff <= ktb_pkg::COUNT_W'(removed_ff);
         o_count_ff   <= ktb_pkg::COUNT_W'(cnt_ff);
         o_bytes_ff   <= bytes_ff;
         o_active_ff  <= permits_ff;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.status         = o_status_ff;
   assign rsp_ch.retry_after_ms = o_retry_ff;
   assign rsp_ch.removed_count  = o_removed_ff;
   assign rsp_ch.entry_count    = o_count_ff;
   assign rsp_ch.key_bytes_used = o_bytes_ff;
   assign rsp_ch.active_total   = o_active_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(TABLE_DEPTH))
      else $error("entry count above table depth");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || rsp_ch.ready))
      else $error("response register overwritten while pending");
   a_done_waited: assert property (@(posedge clock) disable iff (reset)
      mdv_res.done |-> (state_ff == S_RF_WAIT || state_ff == S_RT_WAIT
                        || state_ff == S_PR_FT))
      else $error("divide result arrived with nobody waiting");
   a_shut_sticky: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $past(shut_ff)) |-> shut_ff)
      else $error("closed limiter reopened without reset");
`endif

endmodule

`default_nettype wire

@@ rtl/core/ktb_table.sv @@
// ----------------------------------------------------------------------------
// ktb_table
// Slot table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ktb_table #(
   parameter int DEPTH = ktb_pkg::DEF_TABLE_DEPTH,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output ktb_pkg::slot_type      rd_data,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire ktb_pkg::slot_type wr_data
);

   ktb_pkg::slot_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

@@ rtl/core/ktb_muldiv.sv @@
// ----------------------------------------------------------------------------
// ktb_muldiv
// Serial multiply (one multiplier bit per cycle), optional fraction shift,
// then restoring divide (one quotient bit per cycle).
// ----------------------------------------------------------------------------
`default_nettype none

module ktb_muldiv (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire ktb_pkg::mdv_cmd_type cmd,
   output ktb_pkg::mdv_res_type      res
);

   localparam int STEP_W = $clog2(ktb_pkg::NUM_W + 1);

   typedef enum logic [2:0] {
      MD_IDLE = 3'b001,
      MD_MUL  = 3'b010,
      MD_DIV  = 3'b100
   } md_state_type;

   md_state_type                      state_ff, state_in;
   logic                              done_ff, done_in;
   logic [STEP_W-1:0]                 step_ff, step_in;
   logic [ktb_pkg::PROD_W-1:0]        mcand_ff, mcand_in;
   logic [ktb_pkg::RATE_W-1:0]        mplier_ff, mplier_in;
   logic [ktb_pkg::NUM_W-1:0]         acc_ff, acc_in;
   logic [ktb_pkg::DIV_W-1:0]         rem_ff, rem_in;
   logic [ktb_pkg::DIV_W-1:0]         div_ff, div_in;
   logic                              shift_ff, shift_in;

   always_comb begin
      logic [ktb_pkg::PROD_W-1:0]  prod;
      logic [ktb_pkg::DIV_W:0]     trial;
      logic                        ge;
      state_in  = state_ff;
      done_in   = 1'b0;
      step_in   = step_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      acc_in    = acc_ff;
      rem_in    = rem_ff;
      div_in    = div_ff;
      shift_in  = shift_ff;
      prod  = acc_ff[ktb_pkg::PROD_W-1:0] + (mplier_ff[0] ? mcand_ff : '0);
      trial = {rem_ff, acc_ff[ktb_pkg::NUM_W-1]};
      ge    = trial >= {1'b0, div_ff};
      case (state_ff)
         MD_IDLE: begin
            if (cmd.start) begin
               mcand_in  = ktb_pkg::PROD_W'(cmd.mul_a);
               mplier_in = cmd.mul_b;
               div_in    = cmd.divisor;
               shift_in  = cmd.shift_en;
               acc_in    = '0;
               step_in   = '0;
               state_in  = MD_MUL;
            end
         end
         MD_MUL: begin
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            acc_in    = ktb_pkg::NUM_W'(prod);
            step_in   = step_ff + 1'b1;
            if (step_ff == STEP_W'(ktb_pkg::RATE_W - 1)) begin
               acc_in   = shift_ff ? (ktb_pkg::NUM_W'(prod) << ktb_pkg::FRACTION_BITS)
                                   : ktb_pkg::NUM_W'(prod);
               rem_in   = '0;
               step_in  = '0;
               state_in = MD_DIV;
            end
         end
         MD_DIV: begin
            rem_in  = ge ? ktb_pkg::DIV_W'(trial - {1'b0, div_ff})
                         : trial[ktb_pkg::DIV_W-1:0];
            acc_in  = {acc_ff[ktb_pkg::NUM_W-2:0], ge};
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(ktb_pkg::NUM_W - 1)) begin
               done_in  = 1'b1;
               state_in = MD_IDLE;
            end
         end
         default: state_in = MD_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MD_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff   <= step_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      acc_ff    <= acc_in;
      rem_ff    <= rem_in;
      div_ff    <= div_in;
      shift_ff  <= shift_in;
   end

   assign res.done     = done_ff;
   assign res.quotient = acc_ff;
   assign res.rem_nz   = |rem_ff;

`ifndef SYNTHESIS
   // a new command may only arrive while the unit is free
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> (state_ff == MD_IDLE))
      else $error("muldiv started while busy");
   a_done_from_div: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> ($past(state_ff) == MD_DIV))
      else $error("muldiv done outside divide phase");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("muldiv done longer than one cycle");
`endif

endmodule

`default_nettype wire

@@ dv/tb_keyed_token_bucket_limiter.sv @@
// ----------------------------------------------------------------------------
// tb_keyed_token_bucket_limiter
// Self-checking bench for the keyed token bucket limiter. A short table of
// directed requests (argument refusals, caps, releases, rate refusal, time
// going backwards, extreme keys and times) is followed by random requests
// over several register settings. A cycle-free model of the bucket table
// predicts every response the table does not fix. Sender bursts and receiver stalls vary the load.
// ----------------------------------------------------------------------------
module tb_keyed_token_bucket_limiter;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH          = ktb_pkg::DEF_TABLE_DEPTH;
   localparam int KEY_BYTES_MAX  = ktb_pkg::DEF_MAX_KEY_BYTES;
   localparam int WATCHDOG_LIMIT = 2000000;
   localparam int SETTING_COUNT  = 7;
   localparam int ITEMS_PER_SET  = 260;
   localparam int POOL_SIZE      = 8;
   localparam int MAX_SHOWN      = 10;

   typedef struct {
      ktb_pkg::action_type          act;
      logic [ktb_pkg::TAG_W-1:0]    key;
      logic [ktb_pkg::LEN_W-1:0]    len;
      logic [ktb_pkg::COST_W-1:0]   cost;
      logic [ktb_pkg::TIME_W-1:0]   now;
   } limiter_req_type;

   typedef struct {
      ktb_pkg::status_type           status;
      logic [ktb_pkg::TIME_W-1:0]    retry;
      logic [ktb_pkg::COUNT_W-1:0]   removed;
      logic [ktb_pkg::COUNT_W-1:0]   entries;
      logic [ktb_pkg::BYTES_W-1:0]   bytes;
      logic [ktb_pkg::PERMIT_W-1:0]  permits;
   } limiter_rsp_type;

   typedef struct {
      limiter_req_type  req;
      bit               typed;
      limiter_rsp_type  rsp;
   } plan_row_type;

   logic clock;
   logic reset;
   logic                          csr_we;
   logic [ktb_pkg::CSR_IDX_W-1:0] csr_index;
   logic [ktb_pkg::CSR_W-1:0]     csr_wdata;

   ktb_req_if req_ch();
   ktb_rsp_if rsp_ch();

   keyed_token_bucket_limiter dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // bucket table model
   bit                           b_valid   [DEPTH];
   logic [ktb_pkg::TAG_W-1:0]    b_tag     [DEPTH];
   logic [ktb_pkg::LEN_W-1:0]    b_len     [DEPTH];
   logic [ktb_pkg::TOKEN_W-1:0]  b_tokens  [DEPTH];
   logic [ktb_pkg::PERMIT_W-1:0] b_active  [DEPTH];
   logic [ktb_pkg::TIME_W-1:0]   b_refill_t[DEPTH];
   logic [ktb_pkg::TIME_W-1:0]   b_seen_t  [DEPTH];
   logic [ktb_pkg::BYTES_W-1:0]  bytes_held;
   logic [ktb_pkg::PERMIT_W-1:0] permits_held;
   logic [ktb_pkg::TIME_W-1:0]   hold_until;
   bit                           is_shut;

   logic [ktb_pkg::COUNT_W-1:0]    c_max_keys;
   logic [ktb_pkg::BYTES_W-1:0]    c_max_bytes;
   logic [ktb_pkg::RATE_W-1:0]     c_refill;
   logic [ktb_pkg::RATE_W-1:0]     c_burst;
   logic [ktb_pkg::INTERVAL_W-1:0] c_interval;
   logic [ktb_pkg::IDLE_W-1:0]     c_idle;
   logic [ktb_pkg::PERMIT_W-1:0]   c_per_key;
   logic [ktb_pkg::PERMIT_W-1:0]   c_total;

   limiter_rsp_type pending_rsp[$];
   int errors;
   int accepted;
   int received;
   int pruned_total;
   int status_seen[16];
   int burst_left;
   int idle_cycles;

   logic [ktb_pkg::TAG_W-1:0]  pool_tag[POOL_SIZE];
   logic [ktb_pkg::LEN_W-1:0]  pool_len[POOL_SIZE];
   logic [ktb_pkg::TIME_W-1:0] clock_ms;

   function automatic logic [63:0] eff_refill();
      return (c_refill == 0) ? 64'd1 : 64'(c_refill);
   endfunction

   function automatic logic [63:0] eff_interval();
      return (c_interval == 0) ? 64'd1 : 64'(c_interval);
   endfunction

   function automatic logic [63:0] bucket_cap();
      return 64'(c_burst) << ktb_pkg::FRACTION_BITS;
   endfunction

   // quotient saturates to all ones when it does not fit 64 bits
   function automatic logic [63:0] wide_div(input logic [127:0] num, input logic [63:0] d,
                                            output bit rem_nz);
      logic [127:0] q;
      q = num / 128'(d);
      if (q[127:64] != 0) begin
         rem_nz = 0;
         return '1;
      end
      rem_nz = (num % 128'(d)) != 0;
      return q[63:0];
   endfunction

   function automatic void refill_bucket(int s, logic [ktb_pkg::TIME_W-1:0] now);
      logic [127:0] num;
      logic [63:0]  add;
      logic [63:0]  cap;
      bit           rnz;
      if (now <= b_refill_t[s]) return;
      num = 128'(now - b_refill_t[s]) * 128'(eff_refill());
      num = num << ktb_pkg::FRACTION_BITS;
      add = wide_div(num, eff_interval(), rnz);
      cap = bucket_cap();
      if (add >= cap || 64'(b_tokens[s]) + add >= cap)
         b_tokens[s] = ktb_pkg::TOKEN_W'(cap);
      else
         b_tokens[s] = ktb_pkg::TOKEN_W'(64'(b_tokens[s]) + add);
      b_refill_t[s] = now;
   endfunction

   function automatic logic [ktb_pkg::TIME_W-1:0] full_time(int s);
      logic [63:0]  cap;
      logic [63:0]  missing;
      logic [63:0]  ms;
      logic [63:0]  t;
      bit           rnz;
      cap = bucket_cap();
      missing = (64'(b_tokens[s]) < cap) ? cap - 64'(b_tokens[s]) : 64'd0;
      ms = wide_div(128'(missing) * 128'(eff_interval()),
                    eff_refill() << ktb_pkg::FRACTION_BITS, rnz);
      if (ms > 64'(ktb_pkg::DAY_MS)) ms = 64'(ktb_pkg::DAY_MS);
      t = 64'(b_refill_t[s]) + ms;
      return (t > 64'(ktb_pkg::TIME_MAX)) ? ktb_pkg::TIME_MAX : t[ktb_pkg::TIME_W-1:0];
   endfunction

   function automatic int prune_buckets(logic [ktb_pkg::TIME_W-1:0] now, bit pressure);
      int removed;
      logic [ktb_pkg::TIME_W-1:0] earliest;
      logic [ktb_pkg::TIME_W-1:0] t;
      bit full;
      bit idle;
      removed = 0;
      earliest = ktb_pkg::TIME_MAX;
      for (int s = 0; s < DEPTH; s++) begin
         if (!b_valid[s]) continue;
         refill_bucket(s, now);
         full = 64'(b_tokens[s]) >= bucket_cap();
         idle = now >= b_seen_t[s] && (now - b_seen_t[s]) >= ktb_pkg::TIME_W'(c_idle);
         if (b_active[s] == 0 && (is_shut || (full && (pressure || idle)))) begin
            bytes_held = (bytes_held >= ktb_pkg::BYTES_W'(b_len[s]))
                         ? bytes_held - ktb_pkg::BYTES_W'(b_len[s]) : '0;
            b_valid[s] = 0;
            removed++;
         end else if (b_active[s] == 0) begin
            t = full_time(s);
            if (t < earliest) earliest = t;
         end
      end
      if (pressure) hold_until = earliest;
      return removed;
   endfunction

   function automatic int find_bucket(logic [ktb_pkg::TAG_W-1:0] tag,
                                      logic [ktb_pkg::LEN_W-1:0] len);
      for (int s = 0; s < DEPTH; s++)
         if (b_valid[s] && b_tag[s] == tag && b_len[s] == len) return s;
      return -1;
   endfunction

   function automatic int live_count();
      int n;
      n = 0;
      for (int s = 0; s < DEPTH; s++) n += b_valid[s];
      return n;
   endfunction

   function automatic bit out_of_room(logic [ktb_pkg::LEN_W-1:0] len);
      int n;
      logic [ktb_pkg::BYTES_W-1:0] room;
      n = live_count();
      room = (c_max_bytes > bytes_held) ? c_max_bytes - bytes_held : '0;
      return n >= int'(c_max_keys) || n >= DEPTH || ktb_pkg::BYTES_W'(len) > room;
   endfunction

   function automatic ktb_pkg::status_type acquire_bucket(limiter_req_type r,
                                                          output logic [ktb_pkg::TIME_W-1:0] retry,
                                                          output int removed);
      int f;
      int s;
      logic [63:0] cf;
      logic [63:0] q;
      bit rnz;
      retry = '0;
      removed = 0;
      if (r.len == 0 || r.cost == 0) return ktb_pkg::ST_INVALID;
      if (r.len > KEY_BYTES_MAX || 64'(r.cost) > 64'(c_burst)) return ktb_pkg::ST_TOO_LARGE;
      if (is_shut) return ktb_pkg::ST_CLOSED;
      if (permits_held >= c_total) return ktb_pkg::ST_TOTAL_CONC;
      f = find_bucket(r.key, r.len);
      if (f < 0) begin
         if (out_of_room(r.len) && r.now >= hold_until) removed = prune_buckets(r.now, 1);
         if (out_of_room(r.len)) return ktb_pkg::ST_KEY_CAP;
         s = 0;
         while (s < DEPTH && b_valid[s]) s++;
         if (s >= DEPTH) return ktb_pkg::ST_KEY_CAP;
         b_valid[s]    = 1;
         b_tag[s]      = r.key;
         b_len[s]      = r.len;
         b_tokens[s]   = ktb_pkg::TOKEN_W'(bucket_cap());
         b_active[s]   = '0;
         b_refill_t[s] = r.now;
         b_seen_t[s]   = r.now;
         bytes_held    = bytes_held + ktb_pkg::BYTES_W'(r.len);
         f = s;
      end
      refill_bucket(f, r.now);
      b_seen_t[f] = r.now;
      if (b_active[f] >= c_per_key) return ktb_pkg::ST_KEY_CONC;
      cf = 64'(r.cost) << ktb_pkg::FRACTION_BITS;
      if (64'(b_tokens[f]) < cf) begin
         q = wide_div(128'(cf - 64'(b_tokens[f])) * 128'(eff_interval()),
                      eff_refill() << ktb_pkg::FRACTION_BITS, rnz);
         if (rnz && q < 64'(ktb_pkg::TIME_MAX)) q++;
         if (q < 1) q = 1;
         retry = (q > 64'(ktb_pkg::TIME_MAX)) ? ktb_pkg::TIME_MAX : q[ktb_pkg::TIME_W-1:0];
         return ktb_pkg::ST_RATE;
      end
      b_tokens[f] = ktb_pkg::TOKEN_W'(64'(b_tokens[f]) - cf);
      b_active[f]++;
      permits_held++;
      return ktb_pkg::ST_ADMITTED;
   endfunction

   function automatic limiter_rsp_type predict_limiter(limiter_req_type r);
      limiter_rsp_type p;
      int removed;
      int f;
      p.status = ktb_pkg::ST_DONE;
      p.retry  = '0;
      removed  = 0;
      case (r.act)
         ktb_pkg::ACT_ACQUIRE: p.status = acquire_bucket(r, p.retry, removed);
         ktb_pkg::ACT_RELEASE: begin
            f = find_bucket(r.key, r.len);
            if (f < 0 || b_active[f] == 0) begin
               p.status = ktb_pkg::ST_UNKNOWN_RELEASE;
            end else begin
               b_active[f]--;
               if (permits_held > 0) permits_held--;
               b_seen_t[f] = r.now;
               hold_until = '0;
               if (is_shut) removed = prune_buckets(r.now, 0);
            end
         end
         ktb_pkg::ACT_PRUNE: removed = prune_buckets(r.now, 0);
         default: begin
            is_shut = 1;
            removed = prune_buckets(r.now, 0);
         end
      endcase
      p.removed = ktb_pkg::COUNT_W'(removed);
      p.entries = ktb_pkg::COUNT_W'(live_count());
      p.bytes   = bytes_held;
      p.permits = permits_held;
      return p;
   endfunction

   function automatic void reset_model();
      for (int s = 0; s < DEPTH; s++) b_valid[s] = 0;
      bytes_held   = '0;
      permits_held = '0;
      hold_until   = '0;
      is_shut      = 0;
      c_max_keys   = ktb_pkg::RST_MAX_KEYS;
      c_max_bytes  = ktb_pkg::RST_MAX_BYTES;
      c_refill     = ktb_pkg::RST_REFILL;
      c_burst      = ktb_pkg::RST_BURST;
      c_interval   = ktb_pkg::RST_INTERVAL;
      c_idle       = ktb_pkg::RST_IDLE;
      c_per_key    = ktb_pkg::RST_PER_KEY;
      c_total      = ktb_pkg::RST_TOTAL;
   endfunction

   function automatic plan_row_type mk_row(ktb_pkg::action_type a,
                                           logic [ktb_pkg::TAG_W-1:0] k,
                                           logic [ktb_pkg::LEN_W-1:0] l,
                                           logic [ktb_pkg::COST_W-1:0] c,
                                           logic [ktb_pkg::TIME_W-1:0] n, bit typed,
                                           ktb_pkg::status_type st,
                                           logic [ktb_pkg::TIME_W-1:0] rt,
                                           logic [ktb_pkg::COUNT_W-1:0] en,
                                           logic [ktb_pkg::BYTES_W-1:0] by,
                                           logic [ktb_pkg::PERMIT_W-1:0] pm);
      plan_row_type row;
      row.req   = '{a, k, l, c, n};
      row.typed = typed;
      row.rsp   = '{st, rt, '0, en, by, pm};
      return row;
   endfunction

   // write one register in the DUT and in the shadow copy; caller drops csr_we
   task automatic write_setting(ktb_pkg::csr_index_type idx, logic [ktb_pkg::CSR_W-1:0] v);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      case (idx)
         ktb_pkg::REG_MAX_KEYS:  c_max_keys  = v[ktb_pkg::COUNT_W-1:0];
         ktb_pkg::REG_MAX_BYTES: c_max_bytes = v[ktb_pkg::BYTES_W-1:0];
         ktb_pkg::REG_REFILL:    c_refill    = v[ktb_pkg::RATE_W-1:0];
         ktb_pkg::REG_BURST:     c_burst     = v[ktb_pkg::RATE_W-1:0];
         ktb_pkg::REG_INTERVAL:  c_interval  = v[ktb_pkg::INTERVAL_W-1:0];
         ktb_pkg::REG_IDLE:      c_idle      = v[ktb_pkg::IDLE_W-1:0];
         ktb_pkg::REG_PER_KEY:   c_per_key   = v[ktb_pkg::PERMIT_W-1:0];
         default:                c_total     = v[ktb_pkg::PERMIT_W-1:0];
      endcase
   endtask

   task automatic program_setting(int ph);
      int unsigned v[8];
      case (ph)
         0: v = '{4, 1048576, 1, 4, 100, 500, 2, 4};
         1: v = '{1, 1, 1, 1, 1, 1, 1, 1};
         2: v = '{1024, 268435456, 1000000000, 1000000000, 86400000, 604800000, 1000000,
                  1000000};
         3: v = '{6, 200, 3, 10, 1000, 2000, 3, 8};
         5: v = '{8, 4096, 0, 5, 0, 0, 2, 6};
         default: v = '{$urandom_range(2, 16), $urandom_range(20, 2000), $urandom_range(1, 50),
                        $urandom_range(1, 100), $urandom_range(1, 5000), $urandom_range(1, 10000),
                        $urandom_range(0, 4), $urandom_range(0, 12)};
      endcase
      write_setting(ktb_pkg::REG_MAX_KEYS,  ktb_pkg::CSR_W'(v[0]));
      write_setting(ktb_pkg::REG_MAX_BYTES, ktb_pkg::CSR_W'(v[1]));
      write_setting(ktb_pkg::REG_REFILL,    ktb_pkg::CSR_W'(v[2]));
      write_setting(ktb_pkg::REG_BURST,     ktb_pkg::CSR_W'(v[3]));
      write_setting(ktb_pkg::REG_INTERVAL,  ktb_pkg::CSR_W'(v[4]));
      write_setting(ktb_pkg::REG_IDLE,      ktb_pkg::CSR_W'(v[5]));
      write_setting(ktb_pkg::REG_PER_KEY,   ktb_pkg::CSR_W'(v[6]));
      write_setting(ktb_pkg::REG_TOTAL,     ktb_pkg::CSR_W'(v[7]));
      csr_we <= 1'b0;
   endtask

   task automatic send_request(limiter_req_type r, bit typed, limiter_rsp_type typed_rsp);
      limiter_rsp_type p;
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         burst_left = $urandom_range(1, 24);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_ch.valid      <= 1'b1;
      req_ch.action     <= r.act;
      req_ch.key_id     <= r.key;
      req_ch.key_length <= r.len;
      req_ch.cost       <= r.cost;
      req_ch.now_ms     <= r.now;
      do @(posedge clock); while (!req_ch.ready);
      burst_left--;
      accepted++;
      p = predict_limiter(r);
      pending_rsp.push_back(typed ? typed_rsp : p);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   function automatic logic [ktb_pkg::LEN_W-1:0] pick_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return ktb_pkg::LEN_W'($urandom_range(1, 4));
      if (r < 80) return ktb_pkg::LEN_W'($urandom_range(5, 64));
      if (r < 95) return ktb_pkg::LEN_W'($urandom_range(65, 600));
      return ktb_pkg::LEN_W'($urandom_range(601, KEY_BYTES_MAX));
   endfunction

   function automatic limiter_req_type random_request(bit allow_close);
      limiter_req_type r;
      int pick;
      int k;
      logic [63:0] step_max;
      logic [ktb_pkg::TIME_W-1:0] back;
      step_max = eff_interval() / 2 + 1;
      if (step_max > 64'd268435456) step_max = 64'd268435456;
      clock_ms = clock_ms + ktb_pkg::TIME_W'($urandom_range(0, int'(step_max)));
      r.now = clock_ms;
      if ($urandom_range(0, 19) == 0) begin
         back = ktb_pkg::TIME_W'($urandom_range(0, int'(step_max)));
         r.now = (clock_ms > back) ? clock_ms - back : '0;
      end
      k = $urandom_range(0, POOL_SIZE - 1);
      r.key  = pool_tag[k];
      r.len  = pool_len[k];
      r.cost = ($urandom_range(0, 9) == 0) ? $urandom_range(1, (c_burst == 0) ? 1 : c_burst)
             : $urandom_range(1, (c_burst < 8) ? ((c_burst == 0) ? 1 : c_burst) : 8);
      pick = $urandom_range(0, 99);
      if (allow_close && pick < 2) begin
         r.act = ktb_pkg::ACT_CLOSE;
      end else if (pick < 57) begin
         r.act = ktb_pkg::ACT_ACQUIRE;
      end else if (pick < 87) begin
         r.act = ktb_pkg::ACT_RELEASE;
      end else if (pick < 95) begin
         r.act = ktb_pkg::ACT_PRUNE;
      end else begin
         // malformed or foreign requests
         r.act = ktb_pkg::ACT_ACQUIRE;
         case ($urandom_range(0, 4))
            0: r.len = '0;
            1: r.cost = '0;
            2: r.len = ktb_pkg::LEN_W'($urandom_range(KEY_BYTES_MAX + 1, 8191));
            3: r.cost = $urandom;
            default: begin
               r.act = ktb_pkg::ACT_RELEASE;
               r.key = $urandom;
            end
         endcase
      end
      return r;
   endfunction

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // response checker with its own stall pattern
   initial begin
      limiter_rsp_type got;
      limiter_rsp_type want;
      int cyc;
      int mode;
      rsp_ch.ready = 1'b0;
      cyc = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            got.status  = ktb_pkg::status_type'(rsp_ch.status);
            got.retry   = rsp_ch.retry_after_ms;
            got.removed = rsp_ch.removed_count;
            got.entries = rsp_ch.entry_count;
            got.bytes   = rsp_ch.key_bytes_used;
            got.permits = rsp_ch.active_total;
            received++;
            status_seen[rsp_ch.status]++;
            pruned_total += rsp_ch.removed_count;
            if (pending_rsp.size() == 0) begin
               errors++;
               if (errors <= MAX_SHOWN)
                  $display("response %0d arrived with no request outstanding", received);
            end else begin
               want = pending_rsp.pop_front();
               if (got.status != want.status || got.retry != want.retry ||
                   got.removed != want.removed || got.entries != want.entries ||
                   got.bytes != want.bytes || got.permits != want.permits) begin
                  errors++;
                  if (errors <= MAX_SHOWN) begin
                     $display("rsp %0d mismatch: want st=%0d rt=%0d rm=%0d n=%0d by=%0d act=%0d",
                              received, want.status, want.retry, want.removed, want.entries,
                              want.bytes, want.permits);
                     $display("   got st=%0d rt=%0d rm=%0d n=%0d by=%0d act=%0d",
                              got.status, got.retry, got.removed, got.entries, got.bytes,
                              got.permits);
                  end
               end
            end
         end
         cyc++;
         mode = (cyc / 256) % 4;
         case (mode)
            0: rsp_ch.ready <= 1'b1;
            1: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
            2: rsp_ch.ready <= (cyc % 16) < 8;
            default: rsp_ch.ready <= 1'($urandom_range(0, 1));
         endcase
      end
   end

   initial begin
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", idle_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin
      plan_row_type plan[$];
      limiter_rsp_type unused_rsp;
      limiter_req_type r;
      errors = 0;
      accepted = 0;
      received = 0;
      pruned_total = 0;
      burst_left = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
      reset = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.action     = ktb_pkg::ACT_ACQUIRE;
      req_ch.key_id     = '0;
      req_ch.key_length = '0;
      req_ch.cost       = '0;
      req_ch.now_ms     = '0;
      csr_we    = 1'b0;
      csr_index = ktb_pkg::REG_MAX_KEYS;
      csr_wdata = '0;
      reset_model();
      unused_rsp = '{ktb_pkg::ST_DONE, '0, '0, '0, '0, '0};
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed requests at the reset settings: burst 1, refill 1 per 1000 ms, caps 1
      plan.push_back(mk_row(ktb_pkg::ACT_ACQUIRE, 0, 0, 1, 0, 1,
                            ktb_pkg::ST_INVALID, 0, 0, 0, 0));
      plan.push_back(mk_row(ktb_pkg::ACT_ACQUIRE, 5, 1, 0, 0, 1,
                            ktb_pkg::ST_INVALID, 0, 0, 0, 0));
      plan.push_back(mk_row(ktb_pkg::ACT_ACQUIRE, 5, 4097, 1, 0, 1,
                            ktb_pkg::ST_TOO_LARGE, 0, 0, 0, 0));
      plan.push_back(mk_row(ktb_pkg::ACT_ACQUIRE, 5, 8191, 1, 0, 1,
                            ktb_pkg::ST_TOO_LARGE, 0, 0, 0, 0));
      plan.push_back(mk_row(ktb_pkg::ACT_ACQUIRE, 5, 1, 2, 0, 1,
                            ktb_pkg::ST_TOO_LARGE, 0, 0, 0, 0));
      plan.push_back(mk_row(ktb_pkg::ACT_ACQUIRE, 5, 1, '1, 0, 1,
                            ktb_pkg::ST_TOO_LARGE, 0, 0, 0, 0));
      plan.push_back(mk_row(ktb_pkg::ACT_ACQUIRE, '1, 4096, 1, 100, 1,
                            ktb_pkg::ST_ADMITTED, 0, 1, 4096, 1));
      plan.push_back(mk_row(ktb_pkg::ACT_ACQUIRE, 1, 1, 1, 100, 1,
                            ktb_pkg::ST_TOTAL_CONC, 0, 1, 4096, 1));
      plan.push_back(mk_row(ktb_pkg::ACT_RELEASE, 1, 1, 1, 150, 1,
                            ktb_pkg::ST_UNKNOWN_RELEASE, 0, 1, 4096, 1));
      plan.push_back(mk_row(ktb_pkg::ACT_RELEASE, '1, 4095, 1, 150, 1,
                            ktb_pkg::ST_UNKNOWN_RELEASE, 0, 1, 4096, 1));
      plan.push_back(mk_row(ktb_pkg::ACT_RELEASE, '1, 4096, 1, 200, 1,
                            ktb_pkg::ST_DONE, 0, 1, 4096, 0));
      plan.push_back(mk_row(ktb_pkg::ACT_RELEASE, '1, 4096, 1, 200, 1,
                            ktb_pkg::ST_UNKNOWN_RELEASE, 0, 1, 4096, 0));
      // 200 ms refills 13107 units, leaving 52429 short: 801 ms
      plan.push_back(mk_row(ktb_pkg::ACT_ACQUIRE, '1, 4096, 1, 300, 1,
                            ktb_pkg::ST_RATE, 801, 1, 4096, 0));
      plan.push_back(mk_row(ktb_pkg::ACT_ACQUIRE, '1, 4096, 1, 50, 0,
                            ktb_pkg::ST_DONE, 0, 0, 0, 0));
      plan.push_back(mk_row(ktb_pkg::ACT_PRUNE, 0, 0, 0, 0, 0,
                            ktb_pkg::ST_DONE, 0, 0, 0, 0));
      plan.push_back(mk_row(ktb_pkg::ACT_ACQUIRE, 1, 1, 1, 500, 0,
                            ktb_pkg::ST_DONE, 0, 0, 0, 0));
      plan.push_back(mk_row(ktb_pkg::ACT_RELEASE, 1, 1, 1, 600, 0,
                            ktb_pkg::ST_DONE, 0, 0, 0, 0));
      plan.push_back(mk_row(ktb_pkg::ACT_PRUNE, 0, 0, 0, 70000, 0,
                            ktb_pkg::ST_DONE, 0, 0, 0, 0));
      plan.push_back(mk_row(ktb_pkg::ACT_ACQUIRE, '1, 4096, 1, ktb_pkg::TIME_MAX, 0,
                            ktb_pkg::ST_DONE, 0, 0, 0, 0));
      plan.push_back(mk_row(ktb_pkg::ACT_PRUNE, 0, 0, 0, ktb_pkg::TIME_MAX, 0,
                            ktb_pkg::ST_DONE, 0, 0, 0, 0));
      plan.push_back(mk_row(ktb_pkg::ACT_RELEASE, '1, 4096, 1, ktb_pkg::TIME_MAX, 0,
                            ktb_pkg::ST_DONE, 0, 0, 0, 0));
      plan.push_back(mk_row(ktb_pkg::ACT_ACQUIRE, 32'hA5A5A5A5, 2730, 1,
                            ktb_pkg::TIME_MAX - 1, 0, ktb_pkg::ST_DONE, 0, 0, 0, 0));
      plan.push_back(mk_row(ktb_pkg::ACT_RELEASE, 32'hA5A5A5A5, 2730, 1,
                            ktb_pkg::TIME_MAX, 0, ktb_pkg::ST_DONE, 0, 0, 0, 0));
      foreach (plan[i]) send_request(plan[i].req, plan[i].typed, plan[i].rsp);

      clock_ms = 48'd1000;
      for (int ph = 0; ph < SETTING_COUNT; ph++) begin
         drain();
         program_setting(ph);
         if (ph == 2) clock_ms = {1'b1, 7'd0, 8'($urandom), 32'($urandom)} >> 1;
         for (int k = 0; k < POOL_SIZE; k++) begin
            pool_tag[k] = $urandom;
            pool_len[k] = pick_length();
         end
         for (int n = 0; n < ITEMS_PER_SET; n++) begin
            r = random_request(ph == SETTING_COUNT - 1 && n > ITEMS_PER_SET / 2);
            send_request(r, 0, unused_rsp);
         end
      end
      drain();
      repeat (64) @(posedge clock);
      errors += pending_rsp.size();

      $display("Covered %0d requests over %0d register settings plus the reset defaults.",
               accepted, SETTING_COUNT);
      $display("Seen: %0d admitted, %0d rate, %0d key-cap, %0d conc refusals, %0d pruned.",
               status_seen[ktb_pkg::ST_ADMITTED], status_seen[ktb_pkg::ST_RATE],
               status_seen[ktb_pkg::ST_KEY_CAP],
               status_seen[ktb_pkg::ST_KEY_CONC] + status_seen[ktb_pkg::ST_TOTAL_CONC],
               pruned_total);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("%0d failures", errors);
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
